// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk_i, off while rst_ni is low.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Whenever a holds, c holds in the same cycle.
`define ASSERT_IMPLIES(lbl, a, c) \
  `ASSERT_CLK(lbl, (a) |-> (c))

`endif

// ===== design/pht_pkg.sv =====
`timescale 1ns / 1ps
package pht_pkg;

  localparam int unsigned HANDLE_SLOTS_DEF     = 32;
  localparam int unsigned PAIRS_PER_HANDLE_DEF = 8;
  localparam int unsigned CNT_W                = 6;
  localparam logic [5:0]  ITEM_CAP             = 6'd32;
  localparam int unsigned FQ_DEPTH             = 2;

  typedef enum logic [2:0] {
    KIND_ALLOC     = 3'd0,
    KIND_INSTALL   = 3'd1,
    KIND_UNINSTALL = 3'd2,
    KIND_LOOKUP    = 3'd3,
    KIND_ENUM      = 3'd4,
    KIND_LIST      = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_NO_RES      = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_INSTALL,
    OP_UNINSTALL,
    OP_LOOKUP,
    OP_ENUM,
    OP_LIST,
    OP_BAD
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_RD,
    S_FIND_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LIST_RD,
    S_LIST_ITEM,
    S_ENUM_H,
    S_ENUM_RD,
    S_ENUM_CMP,
    S_ENUM_HIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  handle;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic        key_given;
    logic [63:0] value_in;
    logic        dest_given;
    logic [5:0]  limit;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  item_handle;
    logic [63:0] value_out;
    logic [63:0] found_key_low;
    logic [63:0] found_key_high;
    logic [5:0]  count;
    logic        last;
  } rsp_t;

  // Classified request as handed from front to back.
  typedef struct packed {
    op_e         op;
    logic [4:0]  handle;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic        key_given;
    logic [63:0] value_in;
    logic        dest_given;
    logic [5:0]  limit;
  } cmd_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] value;
  } pair_t;

  function automatic rsp_t rsp_final(status_e st, logic [5:0] cnt);
    rsp_t r;
    r        = '0;
    r.status = st;
    r.count  = cnt;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

// ===== design/pht_front.sv =====
`timescale 1ns / 1ps
module pht_front import pht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  localparam int unsigned PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(FQ_DEPTH + 1);

  cmd_t               fifo_q [FQ_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_QW-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;
  cmd_t               cls;

  // Classify the request.
  always_comb begin
    cls            = '0;
    cls.handle     = req_i.handle;
    cls.key_low    = req_i.key_low;
    cls.key_high   = req_i.key_high;
    cls.key_given  = req_i.key_given;
    cls.value_in   = req_i.value_in;
    cls.dest_given = req_i.dest_given;
    cls.limit      = (req_i.limit > ITEM_CAP) ? ITEM_CAP : req_i.limit;
    unique case (req_i.kind)
      KIND_ALLOC:     cls.op = OP_ALLOC;
      KIND_INSTALL:   cls.op = OP_INSTALL;
      KIND_UNINSTALL: cls.op = OP_UNINSTALL;
      KIND_LOOKUP:    cls.op = OP_LOOKUP;
      KIND_ENUM:      cls.op = OP_ENUM;
      KIND_LIST:      cls.op = OP_LIST;
      default:        cls.op = OP_BAD;
    endcase
  end

  assign full_o      = (cnt_q == CNT_QW'(FQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(FQ_DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(FQ_DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CNT_QW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CNT_QW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_q] <= cls;
    end
  end

endmodule

// ===== design/pht_back.sv =====
`timescale 1ns / 1ps
module pht_back import pht_pkg::*; #(
  parameter int unsigned HANDLE_SLOTS     = HANDLE_SLOTS_DEF,
  parameter int unsigned PAIRS_PER_HANDLE = PAIRS_PER_HANDLE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic empty_o,
  output rsp_t rsp_o
);

  localparam int unsigned HW    = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
  localparam int unsigned AW    = $clog2(HANDLE_SLOTS + 1);
  localparam int unsigned CW    = $clog2(PAIRS_PER_HANDLE + 1);
  localparam int unsigned DEPTH = HANDLE_SLOTS * PAIRS_PER_HANDLE;
  localparam int unsigned AD    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned HVW   = (AW > 5) ? AW : 5;

  function automatic logic [AD-1:0] pair_addr(logic [HW-1:0] h, logic [CW-1:0] i);
    return AD'(AD'(h) * AD'(PAIRS_PER_HANDLE) + AD'(i));
  endfunction

  state_e          state_q, state_d, ret_q, ret_d;
  cmd_t            cur_q, cur_d;
  logic [AW-1:0]   alloc_q, alloc_d;
  logic [CW-1:0]   pc_q [HANDLE_SLOTS];
  logic [CW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   hidx_q, hidx_d;
  logic [AW-1:0]   n_q, n_d;
  logic [5:0]      k_q, k_d;
  rsp_t            pend_q, pend_d;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  pair_t           mem [DEPTH];
  pair_t           rdata_q;
  logic            mem_we;
  logic [AD-1:0]   mem_wa, mem_ra;
  pair_t           mem_wd;

  logic            pc_we;
  logic [HW-1:0]   pc_wsel;
  logic [CW-1:0]   pc_wd;

  logic [HW-1:0]   scan_h;
  logic [CW-1:0]   pc_sel;
  logic            hv, key_hit;
  logic [5:0]      alloc_cnt;

  assign scan_h    = (state_q == S_ENUM_RD || state_q == S_ENUM_CMP) ?
                     hidx_q[HW-1:0] : HW'(cur_q.handle);
  assign pc_sel    = pc_q[scan_h];
  assign hv        = (HVW'(cur_q.handle) < HVW'(alloc_q));
  assign key_hit   = (rdata_q.key_low == cur_q.key_low) &&
                     (rdata_q.key_high == cur_q.key_high);
  assign alloc_cnt = CNT_W'(alloc_q);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign empty_o     = !rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cur_d       = cur_q;
    alloc_d     = alloc_q;
    idx_d       = idx_q;
    hidx_d      = hidx_q;
    n_d         = n_q;
    k_d         = k_q;
    pend_d      = pend_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !pop_i;
    mem_we      = 1'b0;
    mem_wa      = pair_addr(scan_h, idx_q);
    mem_wd      = '0;
    mem_ra      = pair_addr(scan_h, idx_q);
    pc_we       = 1'b0;
    pc_wsel     = scan_h;
    pc_wd       = pc_sel;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cur_d   = cmd_i;
          idx_d   = '0;
          hidx_d  = '0;
          n_d     = '0;
          k_d     = '0;
          ret_d   = S_IDLE;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_EMIT;
        pend_d  = rsp_final(ST_INVALID, alloc_cnt);
        unique case (cur_q.op)
          OP_ALLOC: begin
            if (alloc_q == AW'(HANDLE_SLOTS)) begin
              pend_d = rsp_final(ST_NO_RES, alloc_cnt);
            end else begin
              pc_we   = 1'b1;
              pc_wsel = alloc_q[HW-1:0];
              pc_wd   = '0;
              alloc_d = AW'(alloc_q + 1'b1);
              pend_d  = rsp_final(ST_OK, CNT_W'(alloc_d));
              pend_d.item_handle = 5'(alloc_q);
            end
          end
          OP_INSTALL, OP_UNINSTALL: begin
            if (hv && cur_q.key_given) state_d = S_FIND_RD;
          end
          OP_LOOKUP: begin
            if (hv && cur_q.key_given && cur_q.dest_given) state_d = S_FIND_RD;
          end
          OP_LIST: begin
            if (hv) state_d = S_LIST_RD;
          end
          OP_ENUM:  state_d = S_ENUM_H;
          default:  state_d = S_EMIT;
        endcase
      end

      // Key search over the handle's pairs, one read and one compare per pair.
      S_FIND_RD: begin
        if (idx_q >= pc_sel) begin
          state_d = S_EMIT;
          priority case (cur_q.op)
            OP_INSTALL: begin
              if (pc_sel >= CW'(PAIRS_PER_HANDLE)) begin
                pend_d = rsp_final(ST_NO_RES, alloc_cnt);
              end else begin
                mem_we = 1'b1;
                mem_wa = pair_addr(scan_h, pc_sel);
                mem_wd = '{key_high: cur_q.key_high, key_low: cur_q.key_low,
                           value: cur_q.value_in};
                pc_we  = 1'b1;
                pc_wd  = CW'(pc_sel + 1'b1);
                pend_d = rsp_final(ST_OK, alloc_cnt);
              end
            end
            OP_UNINSTALL: pend_d = rsp_final(ST_NOT_FOUND, alloc_cnt);
            default:      pend_d = rsp_final(ST_UNSUPPORTED, alloc_cnt);
          endcase
        end else begin
          state_d = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (key_hit) begin
          priority case (cur_q.op)
            OP_INSTALL: begin
              mem_we  = 1'b1;
              mem_wd  = '{key_high: cur_q.key_high, key_low: cur_q.key_low,
                          value: cur_q.value_in};
              pend_d  = rsp_final(ST_OK, alloc_cnt);
              state_d = S_EMIT;
            end
            OP_UNINSTALL: state_d = S_SHIFT_RD;
            default: begin
              pend_d           = rsp_final(ST_OK, alloc_cnt);
              pend_d.value_out = rdata_q.value;
              state_d          = S_EMIT;
            end
          endcase
        end else begin
          idx_d   = CW'(idx_q + 1'b1);
          state_d = S_FIND_RD;
        end
      end

      // Compaction: move each later pair down by one.
      S_SHIFT_RD: begin
        if ((CW + 1)'(idx_q) + 1'b1 < (CW + 1)'(pc_sel)) begin
          mem_ra  = pair_addr(scan_h, CW'(idx_q + 1'b1));
          state_d = S_SHIFT_WR;
        end else begin
          pc_we   = 1'b1;
          pc_wd   = CW'(pc_sel - 1'b1);
          pend_d  = rsp_final(ST_OK, alloc_cnt);
          state_d = S_EMIT;
        end
      end

      S_SHIFT_WR: begin
        mem_we  = 1'b1;
        mem_wd  = rdata_q;
        idx_d   = CW'(idx_q + 1'b1);
        state_d = S_SHIFT_RD;
      end

      S_LIST_RD: begin
        if (cur_q.dest_given && idx_q < pc_sel && 6'(idx_q) < cur_q.limit) begin
          state_d = S_LIST_ITEM;
        end else begin
          pend_d  = rsp_final(ST_OK, CNT_W'(pc_sel));
          ret_d   = S_IDLE;
          state_d = S_EMIT;
        end
      end

      S_LIST_ITEM: begin
        pend_d                = '0;
        pend_d.status         = ST_OK;
        pend_d.found_key_low  = rdata_q.key_low;
        pend_d.found_key_high = rdata_q.key_high;
        idx_d                 = CW'(idx_q + 1'b1);
        ret_d                 = S_LIST_RD;
        state_d               = S_EMIT;
      end

      S_ENUM_H: begin
        idx_d = '0;
        if (hidx_q >= alloc_q) begin
          pend_d  = rsp_final(ST_OK, CNT_W'(n_q));
          ret_d   = S_IDLE;
          state_d = S_EMIT;
        end else if (!cur_q.key_given) begin
          state_d = S_ENUM_HIT;
        end else begin
          state_d = S_ENUM_RD;
        end
      end

      S_ENUM_RD: begin
        if (idx_q >= pc_sel) begin
          hidx_d  = AW'(hidx_q + 1'b1);
          state_d = S_ENUM_H;
        end else begin
          state_d = S_ENUM_CMP;
        end
      end

      S_ENUM_CMP: begin
        if (key_hit) begin
          state_d = S_ENUM_HIT;
        end else begin
          idx_d   = CW'(idx_q + 1'b1);
          state_d = S_ENUM_RD;
        end
      end

      S_ENUM_HIT: begin
        n_d    = AW'(n_q + 1'b1);
        hidx_d = AW'(hidx_q + 1'b1);
        if (cur_q.dest_given && k_q < cur_q.limit) begin
          k_d                = 6'(k_q + 1'b1);
          pend_d             = '0;
          pend_d.status      = ST_OK;
          pend_d.item_handle = 5'(hidx_q);
          ret_d              = S_ENUM_H;
          state_d            = S_EMIT;
        end else begin
          state_d = S_ENUM_H;
        end
      end

      S_EMIT: begin
        if (!rsp_valid_q || pop_i) begin
          rsp_d       = pend_q;
          rsp_valid_d = 1'b1;
          state_d     = ret_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      alloc_q     <= '0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < HANDLE_SLOTS; i++) pc_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      alloc_q     <= alloc_d;
      rsp_valid_q <= rsp_valid_d;
      if (pc_we) pc_q[pc_wsel] <= pc_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    hidx_q <= hidx_d;
    n_q    <= n_d;
    k_q    <= k_d;
    pend_q <= pend_d;
    rsp_q  <= rsp_d;
  end

  // Pair storage: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

endmodule

// ===== design/protocol_handle_table_top.sv =====
// Allocate and rejected requests pass through decode and emit into the result register.
// Key search: a memory read and a compare per stored pair; uninstall compaction adds a
// read and a write per moved pair. Enumerate: a visit per handle, a read and a compare
// per pair searched and an emit per item; list keys: a read, an item and an emit per key.
// One request in work at a time. Reset (async, active low) clears handle count, pair
// counts and both queues; pair storage is not cleared, so requests are taken right after.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module protocol_handle_table_top import pht_pkg::*; #(
  parameter int unsigned HANDLE_SLOTS     = HANDLE_SLOTS_DEF,
  parameter int unsigned PAIRS_PER_HANDLE = PAIRS_PER_HANDLE_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // request side
  input  logic push_i,
  input  req_t req_i,
  output logic full_o,
  // result side
  output logic empty_o,
  input  logic pop_i,
  output rsp_t rsp_o
);

  // Front: two-entry queue of classified requests; back runs them.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  pht_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .req_i       (req_i),
    .full_o      (full_o),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Back: sequencer over the pair memory; results leave through a
  // one-entry output register so the next step waits only on a full slot.
  pht_back #(
    .HANDLE_SLOTS     (HANDLE_SLOTS),
    .PAIRS_PER_HANDLE (PAIRS_PER_HANDLE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .rsp_o       (rsp_o)
  );

  // A full request queue always offers work to the back end.
  `ASSERT_IMPLIES(a_full_has_cmd, full_o, cmd_valid)
  // Item results are always ok with zero count.
  `ASSERT_IMPLIES(a_item_ok, !empty_o && !rsp_o.last, rsp_o.status == ST_OK && rsp_o.count == '0)
  // Final results never carry key bits.
  `ASSERT_IMPLIES(a_final_no_key, !empty_o && rsp_o.last, rsp_o.found_key_low == '0)

endmodule
